>>> rtl/fp16_to_int8_affine_quantizer_core_defines.svh
// Assertion macros shared by the quantizer RTL.
`ifndef FP16_TO_INT8_AFFINE_QUANTIZER_CORE_DEFINES_SVH
`define FP16_TO_INT8_AFFINE_QUANTIZER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FP2I_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FP2I_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/fp2i_pkg.sv
// Shared types, codes and widths of the fp16 to int8 quantizer.
package fp2i_pkg;

    localparam int SIG_W     = 24;          // single precision significand, hidden bit included
    localparam int REM_W     = SIG_W + 1;   // partial remainder, always below twice the divisor
    localparam int QUO_W     = SIG_W + 1;   // significand plus round bit
    localparam int EXP_W     = 10;          // unbiased exponent, signed
    localparam int DIV_CELLS = QUO_W;       // one quotient bit per cell

    // Result class carried down the pipe
    localparam logic [1:0] SPEC_NUM  = 2'd0;
    localparam logic [1:0] SPEC_ZERO = 2'd1;
    localparam logic [1:0] SPEC_SAT  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_SCALE    = 2'd0;
    localparam logic [1:0] REG_ZERO_OFS = 2'd1;
    localparam logic [1:0] REG_UNSIGNED = 2'd2;

    typedef struct packed {
        logic                    last;
        logic                    sign;
        logic [1:0]              spec;
        logic signed [EXP_W-1:0] exp;
        logic [REM_W-1:0]        rem;
        logic [QUO_W-1:0]        quo;
    } fp2i_item_t;

endpackage

>>> rtl/fp16_to_int8_affine_quantizer_core.sv
// Top level: fp16 in, scale division, round to integer, zero point, byte clamp.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------
//  in      | in_valid / in_stall  | half_value[15:0], last_in
//  out     | out_valid / out_stall| quant_byte[7:0], last_out
//  cfg     | cfg_valid / cfg_ready| cfg_index[1:0], cfg_data[31:0]
//
// One item per cycle sustained while the skid register is empty; the path runs
// through 29 registers: prep stage loaded at the accepting edge, 25 division cells,
// fp32 round, integer round, output register.
// The division chain is one cell per quotient bit, so the cell count sets latency.
// rst_n is asynchronous, active low; clears valids and config (scale = 1.0).
// A stalled output item holds; one more item lands in the skid register, and
// in_stall rises only while the skid register is full. cfg_ready is always high.
`include "fp16_to_int8_affine_quantizer_core_defines.svh"

module fp16_to_int8_affine_quantizer_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] half_value,
    input  logic        last_in,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  quant_byte,
    output logic        last_out,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SIG_W = fp2i_pkg::SIG_W;
    localparam int EXP_W = fp2i_pkg::EXP_W;
    localparam int NC    = fp2i_pkg::DIV_CELLS;

    // ------------------------------------------------------------------
    // Configuration. The scale is decoded at write time: class flags plus
    // a normalized significand and unbiased exponent for the divider.
    // ------------------------------------------------------------------
    logic                    s_nan_reg, s_inf_reg, s_zero_reg, s_sign_reg;
    logic [SIG_W-1:0]        s_sig_reg;
    logic signed [EXP_W-1:0] s_exp_reg;
    logic signed [31:0]      zero_ofs_reg;
    logic                    unsigned_out_reg;

    logic [7:0]              cs_e;
    logic [22:0]             cs_m;
    logic [4:0]              cs_p;
    logic [SIG_W-1:0]        cs_sig;
    logic signed [EXP_W-1:0] cs_exp;

    always_comb
    begin
        cs_e = cfg_data[30:23];
        cs_m = cfg_data[22:0];
        cs_p = '0;
        for (int i = 0; i < 23; i++)
        begin
            if (cs_m[i])
            begin
                cs_p = 5'(i);
            end
        end
        if (cs_e == 8'd0)
        begin
            // subnormal scale: bring the leading one to the hidden bit
            cs_sig = SIG_W'({1'b0, cs_m} << (5'd23 - cs_p));
            cs_exp = $signed({5'b0, cs_p}) - 10'sd149;
        end
        else
        begin
            cs_sig = {1'b1, cs_m};
            cs_exp = $signed({2'b0, cs_e}) - 10'sd127;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_nan_reg        <= 1'b0;
            s_inf_reg        <= 1'b0;
            s_zero_reg       <= 1'b0;
            s_sign_reg       <= 1'b0;
            s_sig_reg        <= {1'b1, {(SIG_W-1){1'b0}}};
            s_exp_reg        <= '0;
            zero_ofs_reg     <= '0;
            unsigned_out_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fp2i_pkg::REG_SCALE:
                begin
                    s_nan_reg  <= (cs_e == 8'hFF) && (cs_m != '0);
                    s_inf_reg  <= (cs_e == 8'hFF) && (cs_m == '0);
                    s_zero_reg <= (cs_e == 8'h00) && (cs_m == '0);
                    s_sign_reg <= cfg_data[31];
                    s_sig_reg  <= cs_sig;
                    s_exp_reg  <= cs_exp;
                end
                fp2i_pkg::REG_ZERO_OFS:
                begin
                    zero_ofs_reg <= $signed(cfg_data);
                end
                fp2i_pkg::REG_UNSIGNED:
                begin
                    unsigned_out_reg <= cfg_data[0];
                end
                default:
                begin
                    // unmapped index: write is dropped
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipe control: everything moves unless the skid register is full.
    // ------------------------------------------------------------------
    logic skid_full_reg;
    logic en;

    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;

    // ------------------------------------------------------------------
    // Prep stage: widen the half, classify, align dividend to divisor.
    // ------------------------------------------------------------------
    logic                    h_sign;
    logic [4:0]              h_e;
    logic [9:0]              h_m;
    logic [3:0]              h_p;
    logic [10:0]             x_sig;
    logic signed [EXP_W-1:0] x_exp;
    logic                    x_nan, x_inf, x_zero;
    logic [SIG_W-1:0]        dvd;
    logic                    adj;
    fp2i_pkg::fp2i_item_t    prep_next;

    always_comb
    begin
        h_sign = half_value[15];
        h_e    = half_value[14:10];
        h_m    = half_value[9:0];
        h_p    = '0;
        for (int i = 0; i < 10; i++)
        begin
            if (h_m[i])
            begin
                h_p = 4'(i);
            end
        end
        x_nan  = (h_e == 5'h1F) && (h_m != '0);
        x_inf  = (h_e == 5'h1F) && (h_m == '0);
        x_zero = (h_e == 5'h00) && (h_m == '0);
        if (h_e == 5'h00)
        begin
            x_sig = 11'({1'b0, h_m} << (4'd10 - h_p));
            x_exp = $signed({6'b0, h_p}) - 10'sd24;
        end
        else
        begin
            x_sig = {1'b1, h_m};
            x_exp = $signed({5'b0, h_e}) - 10'sd15;
        end

        dvd = {x_sig, 13'b0};
        adj = dvd < s_sig_reg;

        prep_next.last = last_in;
        prep_next.sign = h_sign ^ s_sign_reg;
        prep_next.quo  = '0;
        prep_next.rem  = adj ? {dvd, 1'b0} : {1'b0, dvd};
        prep_next.exp  = x_exp - s_exp_reg - $signed({9'b0, adj});

        // IEEE special cases; NaN results collapse to integer zero
        priority if (x_nan || s_nan_reg)
            prep_next.spec = fp2i_pkg::SPEC_ZERO;
        else if (x_inf)
            prep_next.spec = s_inf_reg ? fp2i_pkg::SPEC_ZERO : fp2i_pkg::SPEC_SAT;
        else if (x_zero)
            prep_next.spec = fp2i_pkg::SPEC_ZERO;
        else if (s_inf_reg)
            prep_next.spec = fp2i_pkg::SPEC_ZERO;
        else if (s_zero_reg)
            prep_next.spec = fp2i_pkg::SPEC_SAT;
        else
            prep_next.spec = fp2i_pkg::SPEC_NUM;
    end

    logic                 chain_valid [NC+1];
    fp2i_pkg::fp2i_item_t chain_item  [NC+1];
    logic                 prep_valid_reg;
    fp2i_pkg::fp2i_item_t prep_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            prep_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prep_item_reg <= prep_next;
        end
    end

    assign chain_valid[0] = prep_valid_reg;
    assign chain_item[0]  = prep_item_reg;

    // ------------------------------------------------------------------
    // Division chain: one quotient bit per cell, MSB first.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NC; g++)
    begin : g_cell
        fp2i_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .divisor   (s_sig_reg),
            .in_valid  (chain_valid[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Round quotient to single precision (nearest even, remainder = sticky).
    // Out-of-range exponents fold into saturate or zero here.
    // ------------------------------------------------------------------
    fp2i_pkg::fp2i_item_t    q;
    logic                    q_up;
    logic [SIG_W:0]          q_sum;
    logic [SIG_W-1:0]        r1_sig_next;
    logic signed [EXP_W-1:0] r1_exp_next;
    logic [1:0]              r1_spec_next;

    always_comb
    begin
        q     = chain_item[NC];
        q_up  = q.quo[0] && ((q.rem != '0) || q.quo[1]);
        q_sum = {1'b0, q.quo[SIG_W:1]} + (SIG_W+1)'(q_up);
        if (q_sum[SIG_W])
        begin
            r1_sig_next = q_sum[SIG_W:1];
            r1_exp_next = q.exp + 10'sd1;
        end
        else
        begin
            r1_sig_next = q_sum[SIG_W-1:0];
            r1_exp_next = q.exp;
        end
        r1_spec_next = q.spec;
        if (q.spec == fp2i_pkg::SPEC_NUM)
        begin
            if (r1_exp_next > 10'sd30)
                r1_spec_next = fp2i_pkg::SPEC_SAT;
            else if (r1_exp_next < -10'sd1)
                r1_spec_next = fp2i_pkg::SPEC_ZERO;
        end
    end

    logic                    r1_valid_reg;
    logic                    r1_last_reg, r1_sign_reg;
    logic [1:0]              r1_spec_reg;
    logic [SIG_W-1:0]        r1_sig_reg;
    logic signed [EXP_W-1:0] r1_exp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r1_valid_reg <= chain_valid[NC];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_last_reg <= q.last;
            r1_sign_reg <= q.sign;
            r1_spec_reg <= r1_spec_next;
            r1_sig_reg  <= r1_sig_next;
            r1_exp_reg  <= r1_exp_next;
        end
    end

    // ------------------------------------------------------------------
    // Round to integer, ties to even. Exponent is -1..30 for numbers.
    // ------------------------------------------------------------------
    logic [47:0]        ir_ext;
    logic [SIG_W-1:0]   ir_trunc;
    logic               ir_up;
    logic [30:0]        ir_mag;
    logic signed [32:0] r2_val_next;

    always_comb
    begin
        ir_ext   = {r1_sig_reg, 24'b0} >> 5'(10'sd23 - r1_exp_reg);
        ir_trunc = ir_ext[47:24];
        ir_up    = ir_ext[23] && ((ir_ext[22:0] != '0) || ir_trunc[0]);
        if (r1_exp_reg >= 10'sd23)
            ir_mag = 31'(r1_sig_reg) << 3'(r1_exp_reg - 10'sd23);
        else
            ir_mag = 31'(ir_trunc) + 31'(ir_up);

        unique case (r1_spec_reg)
            fp2i_pkg::SPEC_NUM:
                r2_val_next = r1_sign_reg ? -$signed({2'b0, ir_mag}) : $signed({2'b0, ir_mag});
            fp2i_pkg::SPEC_SAT:
                r2_val_next = r1_sign_reg ? -33'sd2147483648 : 33'sd2147483647;
            default:
                r2_val_next = '0;
        endcase
    end

    logic               r2_valid_reg;
    logic               r2_last_reg;
    logic signed [32:0] r2_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r2_valid_reg <= r1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_last_reg <= r1_last_reg;
            r2_val_reg  <= r2_val_next;
        end
    end

    // ------------------------------------------------------------------
    // Zero point at full width, then clamp to the byte range.
    // ------------------------------------------------------------------
    logic signed [33:0] zp_sum;
    logic signed [33:0] zp_lo, zp_hi;
    logic [7:0]         fin_byte;

    always_comb
    begin
        zp_sum = {r2_val_reg[32], r2_val_reg} + {{2{zero_ofs_reg[31]}}, zero_ofs_reg};
        zp_lo  = unsigned_out_reg ? 34'sd0   : -34'sd128;
        zp_hi  = unsigned_out_reg ? 34'sd255 : 34'sd127;
        priority if (zp_sum < zp_lo)
            fin_byte = zp_lo[7:0];
        else if (zp_sum > zp_hi)
            fin_byte = zp_hi[7:0];
        else
            fin_byte = zp_sum[7:0];
    end

    // ------------------------------------------------------------------
    // Output register plus one-deep skid.
    // ------------------------------------------------------------------
    logic       out_valid_reg;
    logic [7:0] out_byte_reg, skid_byte_reg;
    logic       out_last_reg, skid_last_reg;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
                skid_full_reg <= 1'b0;
            end
        end
        else if (r2_valid_reg)
        begin
            if (out_free)
                out_valid_reg <= 1'b1;
            else
                skid_full_reg <= 1'b1;
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (out_free)
            begin
                out_byte_reg <= skid_byte_reg;
                out_last_reg <= skid_last_reg;
            end
        end
        else if (r2_valid_reg)
        begin
            if (out_free)
            begin
                out_byte_reg <= fin_byte;
                out_last_reg <= r2_last_reg;
            end
            else
            begin
                skid_byte_reg <= fin_byte;
                skid_last_reg <= r2_last_reg;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign quant_byte = out_byte_reg;
    assign last_out   = out_last_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic skid_load;
    logic r1_num;
    logic r1_exp_ok;

    assign skid_load = !skid_full_reg && r2_valid_reg && !out_free;
    assign r1_num    = r1_valid_reg && (r1_spec_reg == fp2i_pkg::SPEC_NUM);
    assign r1_exp_ok = (r1_exp_reg <= 10'sd30) && (r1_exp_reg >= -10'sd1);

    `FP2I_ASSERT_NOW(a_skid_behind_out, skid_full_reg, out_valid_reg, "skid full, output empty")
    `FP2I_ASSERT_NEXT(a_skid_fills, skid_load, skid_full_reg, "stalled item not in skid")
    `FP2I_ASSERT_NEXT(a_skid_drains, skid_full_reg && !out_stall, !skid_full_reg, "skid stuck")
    `FP2I_ASSERT_NOW(a_num_exp_range, r1_num, r1_exp_ok, "integer stage exponent out of range")

endmodule

>>> rtl/fp2i_div_cell.sv
// One restoring-division cell: develops one quotient bit per item.
module fp2i_div_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [fp2i_pkg::SIG_W-1:0]    divisor,
    input  logic                          in_valid,
    input  fp2i_pkg::fp2i_item_t          in_item,
    output logic                          out_valid,
    output fp2i_pkg::fp2i_item_t          out_item
);

    logic                          valid_reg;
    fp2i_pkg::fp2i_item_t          item_reg;
    fp2i_pkg::fp2i_item_t          item_next;
    logic                          ge;
    logic [fp2i_pkg::REM_W-1:0]    diff;

    always_comb
    begin
        ge        = in_item.rem >= {1'b0, divisor};
        diff      = ge ? (in_item.rem - {1'b0, divisor}) : in_item.rem;
        item_next = in_item;
        // diff < divisor, so the shift never loses a bit
        item_next.rem = {diff[fp2i_pkg::REM_W-2:0], 1'b0};
        item_next.quo = {in_item.quo[fp2i_pkg::QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

>>> bench/fp16_to_int8_affine_quantizer_core_tb.sv
// Self-checking testbench for the fp16 to int8 affine quantizer core.
module fp16_to_int8_affine_quantizer_core_tb;

    typedef struct {
        logic [7:0] qbyte;
        logic       last;
    } quant_result_t;

    // Holds the register mirror, computes each byte, keeps expected bytes in order.
    class quant_scoreboard;
        logic [31:0]   scale;
        int            zofs;
        logic          uns;
        quant_result_t pending_bytes[$];

        function new();
            scale = 32'h3F80_0000;
            zofs  = 0;
            uns   = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == fp2i_pkg::REG_SCALE)
                scale = data;
            else if (idx == fp2i_pkg::REG_ZERO_OFS)
                zofs = int'(data);
            else if (idx == fp2i_pkg::REG_UNSIGNED)
                uns = data[0];
        endfunction

        function logic [7:0] quantize(logic [15:0] h);
            longint              sat, iv, sum, lo, hi, ex, es, e;
            longint unsigned     mx, ms, num, sig, r, mag, rem, half;
            int                  s;
            logic                x_nan, x_inf, x_zero, s_nan, s_inf, s_zero, qs;
            x_nan  = h[14:10] == 5'h1F && h[9:0] != 0;
            x_inf  = h[14:10] == 5'h1F && h[9:0] == 0;
            x_zero = h[14:0] == 0;
            s_nan  = scale[30:23] == 8'hFF && scale[22:0] != 0;
            s_inf  = scale[30:23] == 8'hFF && scale[22:0] == 0;
            s_zero = scale[30:0] == 0;
            qs     = h[15] ^ scale[31];
            sat    = qs ? -longint'(64'd2147483648) : longint'(64'd2147483647);
            if (x_nan || s_nan)
                iv = 0;
            else if (s_zero)
                iv = x_zero ? 0 : sat;
            else if (x_inf)
                iv = s_inf ? 0 : sat;
            else if (s_inf || x_zero)
                iv = 0;
            else
            begin
                // value = mant * 2^exp; normalize both mantissas to 24 bits
                if (h[14:10] == 0)
                begin
                    mx = h[9:0];
                    ex = -24;
                end
                else
                begin
                    mx = {1'b1, h[9:0]};
                    ex = longint'(h[14:10]) - 25;
                end
                if (scale[30:23] == 0)
                begin
                    ms = scale[22:0];
                    es = -149;
                end
                else
                begin
                    ms = {1'b1, scale[22:0]};
                    es = longint'(scale[30:23]) - 150;
                end
                while (mx[23] == 1'b0)
                begin
                    mx = mx << 1;
                    ex = ex - 1;
                end
                while (ms[23] == 1'b0)
                begin
                    ms = ms << 1;
                    es = es - 1;
                end
                e = ex - es;
                if (mx >= ms)
                    num = mx << 23;
                else
                begin
                    num = mx << 24;
                    e   = e - 1;
                end
                sig = num / ms;
                r   = num % ms;
                // quotient rounded to nearest even at single precision
                if (2 * r > ms || (2 * r == ms && sig[0]))
                    sig = sig + 1;
                if (sig[24])
                begin
                    sig = sig >> 1;
                    e   = e + 1;
                end
                if (e >= 31)
                    iv = sat;
                else if (e < -2)
                    iv = 0;   // below one half, always rounds to zero
                else
                begin
                    if (e >= 23)
                        mag = sig << (e - 23);
                    else
                    begin
                        s    = int'(23 - e);
                        mag  = sig >> s;
                        rem  = sig & ((64'd1 << s) - 1);
                        half = 64'd1 << (s - 1);
                        if (rem > half || (rem == half && mag[0]))
                            mag = mag + 1;
                    end
                    iv = qs ? -longint'(mag) : longint'(mag);
                end
            end
            sum = iv + longint'(zofs);
            lo  = uns ? 0 : -128;
            hi  = uns ? 255 : 127;
            if (sum < lo)
                sum = lo;
            if (sum > hi)
                sum = hi;
            return sum[7:0];
        endfunction

        function void note_input(logic [15:0] h, logic l);
            quant_result_t q;
            q.qbyte = quantize(h);
            q.last  = l;
            pending_bytes.push_back(q);
        endfunction

        // Returns an empty string on a match, otherwise a description.
        function string check_result(logic [7:0] b, logic l);
            quant_result_t q;
            if (pending_bytes.size() == 0)
                return $sformatf("unexpected item byte=%02h last=%0b", b, l);
            q = pending_bytes.pop_front();
            if (q.qbyte !== b || q.last !== l)
                return $sformatf("got byte=%02h last=%0b, want byte=%02h last=%0b",
                                 b, l, q.qbyte, q.last);
            return "";
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] half_value;
    logic        last_in;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  quant_byte;
    logic        last_out;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    quant_scoreboard sb;
    int mismatches;
    int items_sent;
    int bytes_checked;
    int send_idle_pct;   // chance per cycle that the sender holds off
    int recv_stall_pct;  // chance per cycle that the receiver stalls

    fp16_to_int8_affine_quantizer_core uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .half_value (half_value),
        .last_in    (last_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .quant_byte (quant_byte),
        .last_out   (last_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Watch all three channels at the edge; inputs change only after it.
    always @(posedge clk)
    begin
        string msg;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_input(half_value, last_in);
            if (out_valid && !out_stall)
            begin
                msg = sb.check_result(quant_byte, last_out);
                bytes_checked++;
                if (msg != "")
                    report_mismatch(msg);
            end
        end
    end

    // Receiver back-pressure, random per cycle.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Leaves cfg_valid high; the caller drops it after the last write.
    task write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Send one item, with random hold-off before it per the sender's idle rate.
    task send_item(input logic [15:0] h, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        half_value <= h;
        last_in    <= l;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    // Drain: every expected byte back, then let the 29-stage pipe settle.
    task drain;
        in_valid <= 1'b0;
        while (sb.pending_bytes.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Random scale: mostly moderate magnitudes, sometimes any pattern.
    function logic [31:0] pick_scale();
        logic [31:0] v;
        v = $urandom();
        if ($urandom_range(3) != 0)
            v[30:23] = 8'($urandom_range(142, 110));
        return v;
    endfunction

    function logic [31:0] pick_offset();
        if ($urandom_range(4) == 0)
            return $urandom();
        return 32'($signed($urandom_range(600)) - 300);
    endfunction

    localparam int N_DIRECTED = 22;
    localparam int N_PHASES   = 12;
    localparam int PHASE_LEN  = 125;

    logic [15:0] directed_vals [N_DIRECTED] = '{
        16'h0000, 16'h8000, 16'h7C00, 16'hFC00, 16'h7E00, 16'hFE01,
        16'h7BFF, 16'hFBFF, 16'h0001, 16'h83FF, 16'h3800, 16'h3E00,
        16'h4100, 16'hB800, 16'hC100, 16'h57F0, 16'h5800, 16'hD808,
        16'h5BF8, 16'h5C00, 16'h3C00, 16'hFFFF
    };

    // Register settings for the first phases: the extreme cases.
    logic [31:0] scale_set [8] = '{
        32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'h7FC0_0001,
        32'h0000_0001, 32'h7F7F_FFFF, 32'hBF80_0000, 32'hFFFF_FFFF
    };
    logic [31:0] ofs_set [8] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0080,
        32'hFFFF_FF80, 32'h0000_0000, 32'h0000_00FF, 32'h0000_0000
    };

    initial
    begin
        sb             = new();
        mismatches     = 0;
        items_sent     = 0;
        bytes_checked  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        half_value = '0;
        last_in    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = fp2i_pkg::REG_SCALE;
        cfg_data   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at the reset settings (scale 1.0, offset 0, signed).
        for (int i = 0; i < N_DIRECTED; i++)
            send_item(directed_vals[i], i[0]);
        drain();

        for (int p = 0; p < N_PHASES; p++)
        begin
            if (p < 8)
            begin
                write_reg(fp2i_pkg::REG_SCALE, scale_set[p]);
                write_reg(fp2i_pkg::REG_ZERO_OFS, ofs_set[p]);
            end
            else
            begin
                write_reg(fp2i_pkg::REG_SCALE, pick_scale());
                write_reg(fp2i_pkg::REG_ZERO_OFS, pick_offset());
            end
            write_reg(fp2i_pkg::REG_UNSIGNED, 32'(p % 2));
            cfg_valid <= 1'b0;
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            for (int i = 0; i < PHASE_LEN; i++)
                send_item(16'($urandom()), 1'($urandom()));
            drain();
        end

        recv_stall_pct = 0;
        if (sb.pending_bytes.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never came out",
                                      sb.pending_bytes.size()));
        $display("Ran %0d items through %0d register settings, %0d bytes checked.",
                 items_sent, N_PHASES + 1, bytes_checked);
        $display("Settings covered zero, infinite, NaN and tiny scales, offset extremes.");
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout waiting for the quantizer");
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/fp2i_pkg.sv
rtl/fp2i_div_cell.sv
rtl/fp16_to_int8_affine_quantizer_core.sv
bench/fp16_to_int8_affine_quantizer_core_tb.sv
